FILE: rtl/sdc_pkg.sv
// Shared widths, types, constants and lookup tables for the serial date converter.
package sdc_pkg;

    // Pipeline depth shared by every datapath lane
    localparam int NUM_STAGES = 8;

    // Field widths
    localparam int SERIAL_W = 22;
    localparam int FRAC_W   = 32;
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;

    // Action codes
    localparam logic ACT_TO_DATE   = 1'b0;
    localparam logic ACT_TO_SERIAL = 1'b1;

    // Phantom 29 Feb 1900 of the 1900 date system
    localparam logic [SERIAL_W-1:0] LEAP_BUG_SERIAL = 22'd60;
    localparam logic [YEAR_W-1:0]   LEAP_BUG_YEAR   = 14'd1900;
    localparam logic [MONTH_W-1:0]  LEAP_BUG_MONTH  = 4'd2;
    localparam logic [DAY_W-1:0]    LEAP_BUG_DAY    = 5'd29;

    // Julian day offsets
    localparam logic [22:0] JD_OFFSET   = 23'd68569 + 23'd2415019;
    localparam logic [24:0] SERIAL_BASE = 25'd2415019 + 25'd32075;
    localparam int          CYCLE_DAYS  = 146097;

    // Serial clamp limits
    localparam logic signed [24:0] SERIAL_LOW_S = 25'sd60;
    localparam logic signed [24:0] SERIAL_MAX_S = 25'sd4194303;

    // Exact reciprocal of 146097 for a 25-bit dividend
    localparam int          DIVN_K   = 43;
    localparam logic [63:0] DIVN_D   = 64'd146097;
    localparam logic [63:0] DIVN_M64 = ((64'd1 << DIVN_K) + DIVN_D - 64'd1) / DIVN_D;
    localparam logic [25:0] DIVN_M   = DIVN_M64[25:0];

    // Exact reciprocal of 1461001 for a 28-bit dividend
    localparam int          DIVI_K   = 49;
    localparam logic [63:0] DIVI_D   = 64'd1461001;
    localparam logic [63:0] DIVI_M64 = ((64'd1 << DIVI_K) + DIVI_D - 64'd1) / DIVI_D;
    localparam logic [28:0] DIVI_M   = DIVI_M64[28:0];

    // Exact reciprocal of 2447 for a 15-bit dividend, premultiplied by 80
    localparam int          DIVJ_K     = 27;
    localparam logic [63:0] DIVJ_D     = 64'd2447;
    localparam logic [63:0] DIVJ_M64   = ((64'd1 << DIVJ_K) + DIVJ_D - 64'd1) / DIVJ_D;
    localparam logic [63:0] DIVJ_M80_L = DIVJ_M64 * 64'd80;
    localparam logic [31:0] DIVJ_M80   = DIVJ_M80_L[31:0];

    // Exact reciprocal of 100 for a 15-bit dividend
    localparam int          DIVC_K   = 22;
    localparam logic [63:0] DIVC_D   = 64'd100;
    localparam logic [63:0] DIVC_M64 = ((64'd1 << DIVC_K) + DIVC_D - 64'd1) / DIVC_D;
    localparam logic [15:0] DIVC_M   = DIVC_M64[15:0];

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } tod_t;

    // floor(2447 * j / 80): days before month index j in a March-based year
    function automatic logic [8:0] days_before_month(input logic [3:0] j);
        logic [8:0] val;
        case (j)
            4'd0:    val = 9'd0;
            4'd1:    val = 9'd30;
            4'd2:    val = 9'd61;
            4'd3:    val = 9'd91;
            4'd4:    val = 9'd122;
            4'd5:    val = 9'd152;
            4'd6:    val = 9'd183;
            4'd7:    val = 9'd214;
            4'd8:    val = 9'd244;
            4'd9:    val = 9'd275;
            4'd10:   val = 9'd305;
            4'd11:   val = 9'd336;
            4'd12:   val = 9'd367;
            4'd13:   val = 9'd397;
            4'd14:   val = 9'd428;
            default: val = 9'd458;
        endcase
        return val;
    endfunction

    // floor(367 * (m - 2 - 12q) / 12) indexed directly by the month field
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [8:0] val;
        case (m)
            4'd0:    val = 9'd305;
            4'd1:    val = 9'd336;
            4'd2:    val = 9'd367;
            4'd3:    val = 9'd30;
            4'd4:    val = 9'd61;
            4'd5:    val = 9'd91;
            4'd6:    val = 9'd122;
            4'd7:    val = 9'd152;
            4'd8:    val = 9'd183;
            4'd9:    val = 9'd214;
            4'd10:   val = 9'd244;
            4'd11:   val = 9'd275;
            4'd12:   val = 9'd305;
            4'd13:   val = 9'd336;
            4'd14:   val = 9'd367;
            default: val = 9'd397;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/sdc_date_path.sv
// Serial-to-calendar-date datapath: Julian day algorithm over eight register stages.
module sdc_date_path
    import sdc_pkg::*;
(
    input  logic                  clk,
    input  logic [NUM_STAGES-1:0] adv,
    input  logic [SERIAL_W-1:0]   serial_day,
    output date_t                 date
);

    // Stage 0: leap-bug shift and Julian offset
    logic [22:0] l0_next;
    logic        leap_next;
    logic [22:0] l0_s0_reg;
    logic [NUM_STAGES-2:0] leap_reg;

    always_comb
    begin
        leap_next = (serial_day == LEAP_BUG_SERIAL);
        if (serial_day < LEAP_BUG_SERIAL)
        begin
            l0_next = 23'(serial_day) + JD_OFFSET + 23'd1;
        end
        else
        begin
            l0_next = 23'(serial_day) + JD_OFFSET;
        end
    end

    // Stage 1: four-century cycle count
    logic [48:0] n_prod;
    logic [7:0]  n_next;
    logic [7:0]  n_s1_reg;
    logic [22:0] l0_s1_reg;

    assign n_prod = 49'(l0_s0_reg) * 49'(DIVN_M);
    assign n_next = n_prod[DIVN_K-2 +: 8];

    // Stage 2: day within cycle and century base of the year
    logic [25:0] cyc_days;
    logic [15:0] la_next;
    logic [14:0] yb_next;
    logic [15:0] la_s2_reg;
    logic [14:0] yb_s2_reg;

    assign cyc_days = 26'(n_s1_reg) * 26'(CYCLE_DAYS);
    assign la_next  = 16'(l0_s1_reg - 23'((cyc_days + 26'd3) >> 2));
    assign yb_next  = 15'(n_s1_reg) * 15'd100;

    // Stage 3: scaled dividend for the year-in-cycle quotient
    logic [27:0] x2_next;
    logic [27:0] x2_s3_reg;
    logic [15:0] la_s3_reg;
    logic [14:0] yb_s3_reg;

    assign x2_next = (28'(la_s2_reg) + 28'd1) * 28'd4000;

    // Stage 4: year within cycle
    logic [56:0] i_prod;
    logic [6:0]  i_next;
    logic [6:0]  i_s4_reg;
    logic [15:0] la_s4_reg;
    logic [14:0] yb_s4_reg;

    assign i_prod = 57'(x2_s3_reg) * 57'(DIVI_M);
    assign i_next = i_prod[DIVI_K +: 7];

    // Stage 5: day within the March-based year
    logic [17:0] yr_days;
    logic [8:0]  l2_next;
    logic [8:0]  l2_s5_reg;
    logic [6:0]  i_s5_reg;
    logic [14:0] yb_s5_reg;

    assign yr_days = 18'(i_s4_reg) * 18'd1461;
    assign l2_next = 9'(18'(la_s4_reg) + 18'd31 - (yr_days >> 2));

    // Stage 6: month index
    logic [31:0] j_prod;
    logic [3:0]  j_next;
    logic [3:0]  j_s6_reg;
    logic [8:0]  l2_s6_reg;
    logic [6:0]  i_s6_reg;
    logic [14:0] yb_s6_reg;

    assign j_prod = 32'(l2_s5_reg) * DIVJ_M80;
    assign j_next = j_prod[DIVJ_K +: 4];

    // Stage 7: final day, month and year, phantom leap day override
    logic  late;
    date_t date_next;
    date_t date_reg;

    always_comb
    begin
        late = (j_s6_reg >= 4'd11);
        if (leap_reg[NUM_STAGES-2])
        begin
            date_next.year  = LEAP_BUG_YEAR;
            date_next.month = LEAP_BUG_MONTH;
            date_next.day   = LEAP_BUG_DAY;
        end
        else
        begin
            date_next.day   = 5'(l2_s6_reg - days_before_month(j_s6_reg));
            date_next.month = late ? (j_s6_reg - 4'd10) : (j_s6_reg + 4'd2);
            date_next.year  = 14'(yb_s6_reg - 15'd4900 + 15'(i_s6_reg) + 15'(late));
        end
    end

    // Advance each stage when its slot frees up
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            l0_s0_reg   <= l0_next;
            leap_reg[0] <= leap_next;
        end
        for (int k = 1; k < NUM_STAGES - 1; k++)
        begin
            if (adv[k])
            begin
                leap_reg[k] <= leap_reg[k-1];
            end
        end
        if (adv[1])
        begin
            n_s1_reg  <= n_next;
            l0_s1_reg <= l0_s0_reg;
        end
        if (adv[2])
        begin
            la_s2_reg <= la_next;
            yb_s2_reg <= yb_next;
        end
        if (adv[3])
        begin
            x2_s3_reg <= x2_next;
            la_s3_reg <= la_s2_reg;
            yb_s3_reg <= yb_s2_reg;
        end
        if (adv[4])
        begin
            i_s4_reg  <= i_next;
            la_s4_reg <= la_s3_reg;
            yb_s4_reg <= yb_s3_reg;
        end
        if (adv[5])
        begin
            l2_s5_reg <= l2_next;
            i_s5_reg  <= i_s4_reg;
            yb_s5_reg <= yb_s4_reg;
        end
        if (adv[6])
        begin
            j_s6_reg  <= j_next;
            l2_s6_reg <= l2_s5_reg;
            i_s6_reg  <= i_s5_reg;
            yb_s6_reg <= yb_s5_reg;
        end
        if (adv[7])
        begin
            date_reg <= date_next;
        end
    end

    assign date = date_reg;

endmodule

FILE: rtl/sdc_time_path.sv
// Day-fraction-to-time datapath: hour and rounded minute, then delay to the pipeline depth.
module sdc_time_path
    import sdc_pkg::*;
(
    input  logic                  clk,
    input  logic [NUM_STAGES-1:0] adv,
    input  logic [FRAC_W-1:0]     day_fraction,
    output tod_t                  tod
);

    localparam int TOD_DONE = 3;

    // Stage 0: scale by 24, split hour and remainder
    logic [36:0]         t_next;
    logic [HOUR_W-1:0]   hour_s0_reg;
    logic [FRAC_W-1:0]   rem_s0_reg;

    assign t_next = 37'(day_fraction) * 37'd24;

    // Stage 1: remainder times 60
    logic [37:0]         mp_next;
    logic [37:0]         mp_s1_reg;
    logic [HOUR_W-1:0]   hour_s1_reg;

    assign mp_next = 38'(rem_s0_reg) * 38'd60;

    // Stage 2: round half up to the minute
    logic [38:0]         mr_sum;
    logic [MINUTE_W-1:0] min_next;
    logic [MINUTE_W-1:0] min_s2_reg;
    logic [HOUR_W-1:0]   hour_s2_reg;

    assign mr_sum   = 39'(mp_s1_reg) + 39'h0_8000_0000;
    assign min_next = MINUTE_W'(mr_sum >> 32);

    // Stage 3: fold a rounded-up 60 into the hour
    tod_t tod_next;
    tod_t tod_reg [TOD_DONE:NUM_STAGES-1];

    always_comb
    begin
        if (min_s2_reg == 6'd60)
        begin
            tod_next.minute = '0;
            tod_next.hour   = hour_s2_reg + 5'd1;
        end
        else
        begin
            tod_next.minute = min_s2_reg;
            tod_next.hour   = hour_s2_reg;
        end
    end

    // Advance stages; hold the finished time until the date lane catches up
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            hour_s0_reg <= t_next[36:32];
            rem_s0_reg  <= t_next[31:0];
        end
        if (adv[1])
        begin
            mp_s1_reg   <= mp_next;
            hour_s1_reg <= hour_s0_reg;
        end
        if (adv[2])
        begin
            min_s2_reg  <= min_next;
            hour_s2_reg <= hour_s1_reg;
        end
        if (adv[TOD_DONE])
        begin
            tod_reg[TOD_DONE] <= tod_next;
        end
        for (int k = TOD_DONE + 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                tod_reg[k] <= tod_reg[k-1];
            end
        end
    end

    assign tod = tod_reg[NUM_STAGES-1];

endmodule

FILE: rtl/sdc_serial_path.sv
// Date-to-serial datapath: Julian day number, leap-bug shift and clamp, then delay.
module sdc_serial_path
    import sdc_pkg::*;
(
    input  logic                  clk,
    input  logic [NUM_STAGES-1:0] adv,
    input  logic [YEAR_W-1:0]     in_year,
    input  logic [MONTH_W-1:0]    in_month,
    input  logic [DAY_W-1:0]      in_day,
    output logic [SERIAL_W-1:0]   serial
);

    localparam int SER_DONE = 4;

    // Stage 0: January and February belong to the previous year
    logic        qneg;
    logic [14:0] ya_next;
    logic [14:0] yc_next;
    logic        special_next;
    logic [14:0] ya_s0_reg;
    logic [14:0] yc_s0_reg;
    logic [8:0]  t2_s0_reg;
    logic [DAY_W-1:0] dd_s0_reg;
    logic [SER_DONE-1:0] special_reg;

    assign qneg         = (in_month < 4'd3);
    assign ya_next      = 15'(in_year) + 15'd4800 - 15'(qneg);
    assign yc_next      = 15'(in_year) + 15'd4900 - 15'(qneg);
    assign special_next = (in_day == LEAP_BUG_DAY) && (in_month == LEAP_BUG_MONTH)
                          && (in_year == LEAP_BUG_YEAR);

    // Stage 1: year days and century count
    logic [24:0] yd_prod;
    logic [30:0] c_prod;
    logic [22:0] t1_s1_reg;
    logic [7:0]  c_s1_reg;
    logic [8:0]  t2_s1_reg;
    logic [DAY_W-1:0] dd_s1_reg;

    assign yd_prod = 25'(ya_s0_reg) * 25'd1461;
    assign c_prod  = 31'(yc_s0_reg) * 31'(DIVC_M);

    // Stage 2: century correction and partial sum
    logic [9:0]  c3;
    logic [7:0]  t3_next;
    logic [23:0] part_next;
    logic [7:0]  t3_s2_reg;
    logic [23:0] part_s2_reg;

    assign c3        = 10'(c_s1_reg) * 10'd3;
    assign t3_next   = 8'(c3 >> 2);
    assign part_next = 24'(t1_s1_reg) + 24'(t2_s1_reg) + 24'(dd_s1_reg);

    // Stage 3: raw serial, may be negative
    logic signed [24:0] s_next;
    logic signed [24:0] s_s3_reg;

    assign s_next = $signed(25'(part_s2_reg) - 25'(t3_s2_reg) - SERIAL_BASE);

    // Stage 4: leap-bug shift, phantom day override, clamp
    logic signed [24:0]  s_adj;
    logic [SERIAL_W-1:0] ser_next;
    logic [SERIAL_W-1:0] ser_reg [SER_DONE:NUM_STAGES-1];

    always_comb
    begin
        s_adj = (s_s3_reg < SERIAL_LOW_S) ? (s_s3_reg - 25'sd1) : s_s3_reg;
        if (special_reg[SER_DONE-1])
        begin
            ser_next = LEAP_BUG_SERIAL;
        end
        else if (s_adj < 25'sd0)
        begin
            ser_next = '0;
        end
        else if (s_adj > SERIAL_MAX_S)
        begin
            ser_next = '1;
        end
        else
        begin
            ser_next = s_adj[SERIAL_W-1:0];
        end
    end

    // Advance stages; hold the finished serial until the date lane catches up
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ya_s0_reg      <= ya_next;
            yc_s0_reg      <= yc_next;
            t2_s0_reg      <= month_offset(in_month);
            dd_s0_reg      <= in_day;
            special_reg[0] <= special_next;
        end
        for (int k = 1; k < SER_DONE; k++)
        begin
            if (adv[k])
            begin
                special_reg[k] <= special_reg[k-1];
            end
        end
        if (adv[1])
        begin
            t1_s1_reg <= 23'(yd_prod >> 2);
            c_s1_reg  <= c_prod[DIVC_K +: 8];
            t2_s1_reg <= t2_s0_reg;
            dd_s1_reg <= dd_s0_reg;
        end
        if (adv[2])
        begin
            t3_s2_reg   <= t3_next;
            part_s2_reg <= part_next;
        end
        if (adv[3])
        begin
            s_s3_reg <= s_next;
        end
        if (adv[SER_DONE])
        begin
            ser_reg[SER_DONE] <= ser_next;
        end
        for (int k = SER_DONE + 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                ser_reg[k] <= ser_reg[k-1];
            end
        end
    end

    assign serial = ser_reg[NUM_STAGES-1];

endmodule

FILE: rtl/spreadsheet_serial_date_convert.sv
// Top level of the spreadsheet 1900-system serial date converter.
//
// Input channel (in_valid/in_ready) carries one item: an action bit plus
// the fields for either direction. Action 0 turns serial_day and
// day_fraction into year, month, day, hour and rounded minute (hour may
// read 24 after a minute carry; the date does not roll). Action 1 turns
// in_year/in_month/in_day into out_serial. Unused result fields are zero.
// Serial 60 maps to 29 Feb 1900 both ways.
//
// Output channel (out_valid/out_ready) returns one result per item, in order.
// An accepted item passes through stages 0 to 7 in order and out_valid rises
// when it reaches stage 7; while out_ready stays high one item per cycle is
// sustained. The depth is set by the date lane: three reciprocal multiplies,
// each with its own stage, plus the setup and correction stages around them.
// Each stage has its own valid bit. When out_ready is low the last stage
// holds and empty stages behind it keep filling; in_ready drops only when
// all 8 stages hold items. Reset clears every valid bit; data is kept.
module spreadsheet_serial_date_convert
    import sdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                action,
    input  logic [SERIAL_W-1:0] serial_day,
    input  logic [FRAC_W-1:0]   day_fraction,
    input  logic [YEAR_W-1:0]   in_year,
    input  logic [MONTH_W-1:0]  in_month,
    input  logic [DAY_W-1:0]    in_day,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [YEAR_W-1:0]   out_year,
    output logic [MONTH_W-1:0]  out_month,
    output logic [DAY_W-1:0]    out_day,
    output logic [HOUR_W-1:0]   out_hour,
    output logic [MINUTE_W-1:0] out_minute,
    output logic [SERIAL_W-1:0] out_serial
);

    logic [NUM_STAGES:0]   adv;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] act_reg;
    logic [NUM_STAGES-1:0] act_next;
    date_t                 date;
    tod_t                  tod;
    logic [SERIAL_W-1:0]   serial;

    // A stage may load when it is empty or its item moves on
    always_comb
    begin
        adv[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            adv[k] = ~valid_reg[k] | adv[k+1];
        end
    end

    // Shift valid bits and the action code along with the data
    always_comb
    begin
        if (adv[0])
        begin
            valid_next[0] = in_valid;
            act_next[0]   = action;
        end
        else
        begin
            valid_next[0] = valid_reg[0];
            act_next[0]   = act_reg[0];
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
                act_next[k]   = act_reg[k-1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
                act_next[k]   = act_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
    end

    sdc_date_path u_date (
        .clk        (clk),
        .adv        (adv[NUM_STAGES-1:0]),
        .serial_day (serial_day),
        .date       (date)
    );

    sdc_time_path u_time (
        .clk          (clk),
        .adv          (adv[NUM_STAGES-1:0]),
        .day_fraction (day_fraction),
        .tod          (tod)
    );

    sdc_serial_path u_serial (
        .clk      (clk),
        .adv      (adv[NUM_STAGES-1:0]),
        .in_year  (in_year),
        .in_month (in_month),
        .in_day   (in_day),
        .serial   (serial)
    );

    // Drop the fields that the item's action does not produce
    assign in_ready   = adv[0];
    assign out_valid  = valid_reg[NUM_STAGES-1];
    assign out_year   = (act_reg[NUM_STAGES-1] == ACT_TO_DATE) ? date.year  : '0;
    assign out_month  = (act_reg[NUM_STAGES-1] == ACT_TO_DATE) ? date.month : '0;
    assign out_day    = (act_reg[NUM_STAGES-1] == ACT_TO_DATE) ? date.day   : '0;
    assign out_hour   = (act_reg[NUM_STAGES-1] == ACT_TO_DATE) ? tod.hour   : '0;
    assign out_minute = (act_reg[NUM_STAGES-1] == ACT_TO_DATE) ? tod.minute : '0;
    assign out_serial = (act_reg[NUM_STAGES-1] == ACT_TO_SERIAL) ? serial   : '0;

endmodule

FILE: rtl/sdc_checker.sv
// Port-level checker for the serial date converter and its bind to the top level.
module sdc_checker
    import sdc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [YEAR_W-1:0]   out_year,
    input logic [MONTH_W-1:0]  out_month,
    input logic [DAY_W-1:0]    out_day,
    input logic [HOUR_W-1:0]   out_hour,
    input logic [MINUTE_W-1:0] out_minute,
    input logic [SERIAL_W-1:0] out_serial
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_year) && $stable(out_month)
            && $stable(out_day) && $stable(out_hour) && $stable(out_minute)
            && $stable(out_serial))
        else $error("stalled result changed");

    // Input backpressure only when the last stage holds a result and is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low with room in the pipeline");

    // Time and month fields stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_hour <= 5'd24 && out_minute <= 6'd59 && out_month <= 4'd12)
        else $error("time or month field out of range");

    // Only one direction's fields carry data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_serial == '0 || (out_year == '0 && out_month == '0
            && out_day == '0 && out_hour == '0 && out_minute == '0))
        else $error("both result groups nonzero");

endmodule

bind spreadsheet_serial_date_convert sdc_checker u_sdc_checker (.*);
